// ----- rtl/gszr_pkg.sv -----
// shared types, codes and widths for the gated sample zero-run encoder
// no dependencies; used by every module of the block
package gszr_pkg;

    localparam int INDEX_BITS = 24;

    localparam int HALF_W   = 16;
    localparam int SHIFT_W  = 17;
    localparam int SAMPLE_W = 18;
    localparam int PAIR_W   = 19;
    localparam int VALUE_W  = 26;
    localparam int SCAN_W   = 32;
    localparam int SSN_W    = 31;
    localparam int PTS_W    = 24;
    localparam int NZ_W     = 24;
    localparam int SUM_W    = 48;
    localparam int PEAK_W   = 17;
    localparam int TIME_W   = 64;
    localparam int WPOS_W   = 16;
    localparam int FVH_W    = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CNT_W      = 3;

    // input commands
    localparam logic [1:0] CMD_HEADER = 2'd0;
    localparam logic [1:0] CMD_WORD   = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_RUN     = 2'd0;
    localparam logic [1:0] KIND_SAMPLE  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // operations handed from the front stage to the merge stage
    localparam logic [1:0] OP_GAP     = 2'd0;
    localparam logic [1:0] OP_SAMPLES = 2'd1;
    localparam logic [1:0] OP_SUMMARY = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SCAN_START = 2'd0;
    localparam logic [1:0] REG_POST_TRIG  = 2'd1;
    localparam logic [1:0] REG_RANGE      = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic [VALUE_W-1:0]  gap;
        logic [SAMPLE_W-1:0] v0;
        logic [SAMPLE_W-1:0] v1;
        logic                e0;
        logic [PAIR_W-1:0]   pair;
        logic [TIME_W-1:0]   trig_time;
    } s1_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [VALUE_W-1:0]  value;
        logic [SCAN_W-1:0]   scan_number;
        logic [NZ_W-1:0]     sample_count;
        logic [SUM_W-1:0]    total_count;
        logic [PEAK_W-1:0]   peak_value;
        logic [VALUE_W-1:0]  peak_position;
        logic [TIME_W-1:0]   time_out;
        logic                last;
    } res_t;

endpackage

// ----- rtl/gszr_lane.sv -----
// one sample lane: sign-extends a 16-bit half-word and adds the range shift
// depends on gszr_pkg
module gszr_lane (
    input  logic [gszr_pkg::HALF_W-1:0]   half,
    input  logic [gszr_pkg::SHIFT_W-1:0]  shift,
    output logic [gszr_pkg::SAMPLE_W-1:0] sample_val
);

    logic [gszr_pkg::SAMPLE_W-1:0] half_ext;
    logic [gszr_pkg::SAMPLE_W-1:0] shift_ext;

    assign half_ext  = {{(gszr_pkg::SAMPLE_W - gszr_pkg::HALF_W){half[gszr_pkg::HALF_W-1]}},
                        half};
    assign shift_ext = {{(gszr_pkg::SAMPLE_W - gszr_pkg::SHIFT_W){shift[gszr_pkg::SHIFT_W-1]}},
                        shift};

    assign sample_val = half_ext + shift_ext;

endmodule

// ----- rtl/gszr_merge.sv -----
// merge stage: combines the two lane samples into the per-trigger totals and
// forms up to two results per request; depends on gszr_pkg
module gszr_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  gszr_pkg::s1_t               s1,
    input  logic [gszr_pkg::SSN_W-1:0]  scan_start,
    output gszr_pkg::res_t              res0,
    output gszr_pkg::res_t              res1,
    output logic [1:0]                  res_n
);

    logic [gszr_pkg::VALUE_W-1:0] zt_reg, zt_next;
    logic [gszr_pkg::NZ_W-1:0]    nz_reg, nz_next;
    logic [gszr_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [gszr_pkg::PEAK_W-1:0]  peak_reg, peak_next;
    logic [gszr_pkg::VALUE_W-1:0] ppos_reg, ppos_next;
    logic [gszr_pkg::SCAN_W-1:0]  trig_reg, trig_next;

    logic [gszr_pkg::VALUE_W-1:0] pos0;
    logic [gszr_pkg::VALUE_W-1:0] pos1;
    logic [gszr_pkg::PEAK_W-1:0]  pk_mid;
    logic [gszr_pkg::VALUE_W-1:0] pp_mid;
    logic [gszr_pkg::VALUE_W-1:0] v0_ext;
    logic [gszr_pkg::VALUE_W-1:0] v1_ext;
    logic [gszr_pkg::SUM_W-1:0]   pair_ext;
    logic                         hit0;
    logic                         hit1;

    assign pos0 = zt_reg + gszr_pkg::VALUE_W'(nz_reg);
    assign pos1 = pos0 + gszr_pkg::VALUE_W'(s1.e0);

    assign v0_ext = {{(gszr_pkg::VALUE_W - gszr_pkg::SAMPLE_W){s1.v0[gszr_pkg::SAMPLE_W-1]}},
                     s1.v0};
    assign v1_ext = {{(gszr_pkg::VALUE_W - gszr_pkg::SAMPLE_W){s1.v1[gszr_pkg::SAMPLE_W-1]}},
                     s1.v1};
    assign pair_ext = {{(gszr_pkg::SUM_W - gszr_pkg::PAIR_W){s1.pair[gszr_pkg::PAIR_W-1]}},
                       s1.pair};

    // strictly larger and positive: earliest peak wins, low lane before high lane
    assign hit0   = s1.e0 && !s1.v0[gszr_pkg::SAMPLE_W-1]
                    && (s1.v0[gszr_pkg::PEAK_W-1:0] > peak_reg);
    assign pk_mid = hit0 ? s1.v0[gszr_pkg::PEAK_W-1:0] : peak_reg;
    assign pp_mid = hit0 ? pos0 : ppos_reg;
    assign hit1   = !s1.v1[gszr_pkg::SAMPLE_W-1] && (s1.v1[gszr_pkg::PEAK_W-1:0] > pk_mid);

    always_comb
    begin
        res0      = '0;
        res1      = '0;
        res_n     = 2'd0;
        zt_next   = zt_reg;
        nz_next   = nz_reg;
        sum_next  = sum_reg;
        peak_next = peak_reg;
        ppos_next = ppos_reg;
        trig_next = trig_reg;
        unique case (s1.op)
            gszr_pkg::OP_GAP:
            begin
                zt_next = zt_reg + s1.gap;
                if (s1.gap != '0)
                begin
                    res0.kind  = gszr_pkg::KIND_RUN;
                    res0.value = '0 - s1.gap;
                    res0.last  = 1'b1;
                    res_n      = 2'd1;
                end
            end
            gszr_pkg::OP_SAMPLES:
            begin
                peak_next = hit1 ? s1.v1[gszr_pkg::PEAK_W-1:0] : pk_mid;
                ppos_next = hit1 ? pos1 : pp_mid;
                nz_next   = nz_reg + (s1.e0 ? gszr_pkg::NZ_W'(2) : gszr_pkg::NZ_W'(1));
                sum_next  = sum_reg + pair_ext;
                if (s1.e0)
                begin
                    res0.kind  = gszr_pkg::KIND_SAMPLE;
                    res0.value = v0_ext;
                    res1.kind  = gszr_pkg::KIND_SAMPLE;
                    res1.value = v1_ext;
                    res1.last  = 1'b1;
                    res_n      = 2'd2;
                end
                else
                begin
                    res0.kind  = gszr_pkg::KIND_SAMPLE;
                    res0.value = v1_ext;
                    res0.last  = 1'b1;
                    res_n      = 2'd1;
                end
            end
            gszr_pkg::OP_SUMMARY:
            begin
                res0.kind          = gszr_pkg::KIND_SUMMARY;
                res0.scan_number   = gszr_pkg::SCAN_W'(scan_start) + trig_reg;
                res0.sample_count  = nz_reg;
                res0.total_count   = sum_reg;
                res0.peak_value    = peak_reg;
                res0.peak_position = ppos_reg;
                res0.time_out      = s1.trig_time;
                res0.last          = 1'b1;
                res_n              = 2'd1;
                trig_next          = trig_reg + gszr_pkg::SCAN_W'(1);
                zt_next            = '0;
                nz_next            = '0;
                sum_next           = '0;
                peak_next          = '0;
                ppos_next          = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zt_reg   <= '0;
            nz_reg   <= '0;
            sum_reg  <= '0;
            peak_reg <= '0;
            ppos_reg <= '0;
            trig_reg <= '0;
        end
        else if (fire)
        begin
            zt_reg   <= zt_next;
            nz_reg   <= nz_next;
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
            ppos_reg <= ppos_next;
            trig_reg <= trig_next;
        end
    end

endmodule

// ----- rtl/gated_sample_zero_run_encoder_unit.sv -----
// top level: configuration port, gate tracking front stage, two sample lanes,
// merge stage and result queue; depends on gszr_pkg, gszr_lane, gszr_merge
//
//  channel   signals                                   direction
//  item      item_valid / item_stall + payload         in
//  result    result_valid / result_stall + payload     out
//  config    psel penable pwrite paddr pwdata prdata   in/out
//
// a sample word giving two samples pushes two results into the 4-entry queue, which the
// single result port drains; a header or end-of-trigger request pushes at most one
// a taken request passes the front register and then the queue before its result appears
// reset clears all control state at once; there is no clearing pass
// item_stall rises only while the merge stage waits for two free queue entries
module gated_sample_zero_run_encoder_unit (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [1:0]                         cmd,
    input  logic [31:0]                        sample_word,
    input  logic [gszr_pkg::INDEX_BITS-1:0]    gate_start,
    input  logic [gszr_pkg::INDEX_BITS-1:0]    gate_stop,
    input  logic [gszr_pkg::FVH_W-1:0]         first_valid_half,
    input  logic [gszr_pkg::TIME_W-1:0]        trigger_time,

    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [1:0]                         kind,
    output logic [gszr_pkg::VALUE_W-1:0]       value,
    output logic [gszr_pkg::SCAN_W-1:0]        scan_number,
    output logic [gszr_pkg::NZ_W-1:0]          sample_count,
    output logic [gszr_pkg::SUM_W-1:0]         total_count,
    output logic [gszr_pkg::PEAK_W-1:0]        peak_value,
    output logic [gszr_pkg::VALUE_W-1:0]       peak_position,
    output logic [gszr_pkg::TIME_W-1:0]        time_out,
    output logic                               last,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    // configuration registers
    logic [gszr_pkg::SSN_W-1:0]   ssn_reg;
    logic [gszr_pkg::PTS_W-1:0]   pts_reg;
    logic [gszr_pkg::SHIFT_W-1:0] shift_reg;
    logic                         cfg_wr;

    // front stage gate tracking
    logic                             first_gate_reg, first_gate_next;
    logic                             gate_empty_reg, gate_empty_next;
    logic [gszr_pkg::INDEX_BITS-1:0]  prev_stop_reg, prev_stop_next;
    logic [gszr_pkg::WPOS_W-1:0]      wpos_reg, wpos_next;
    logic [gszr_pkg::WPOS_W-2:0]      skip_reg, skip_next;
    logic                             odd_reg, odd_next;

    logic                         s1_v_reg, s1_v_next;
    gszr_pkg::s1_t                s1_reg, s1_next;
    logic                         item_take;
    logic                         fire;

    logic [gszr_pkg::SAMPLE_W-1:0] lane_lo;
    logic [gszr_pkg::SAMPLE_W-1:0] lane_hi;
    logic [gszr_pkg::VALUE_W-1:0]  start_w;
    logic [gszr_pkg::PAIR_W-1:0]   lo_ext;
    logic [gszr_pkg::PAIR_W-1:0]   hi_ext;

    gszr_pkg::res_t               res0;
    gszr_pkg::res_t               res1;
    logic [1:0]                   merge_n;

    // result queue
    gszr_pkg::res_t               fifo_mem [gszr_pkg::FIFO_DEPTH];
    logic [gszr_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gszr_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gszr_pkg::CNT_W-1:0]   fifo_count_reg, fifo_count_next;
    logic [1:0]                   push_n;
    logic                         pop;
    gszr_pkg::res_t               head;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssn_reg   <= '0;
            pts_reg   <= '0;
            shift_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                gszr_pkg::REG_SCAN_START: ssn_reg   <= pwdata[gszr_pkg::SSN_W-1:0];
                gszr_pkg::REG_POST_TRIG:  pts_reg   <= pwdata[gszr_pkg::PTS_W-1:0];
                gszr_pkg::REG_RANGE:      shift_reg <= pwdata[gszr_pkg::SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gszr_pkg::REG_SCAN_START: prdata = 32'(ssn_reg);
            gszr_pkg::REG_POST_TRIG:  prdata = 32'(pts_reg);
            gszr_pkg::REG_RANGE:      prdata = 32'(shift_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- sample lanes ----------------
    gszr_lane u_lane_lo (
        .half       (sample_word[15:0]),
        .shift      (shift_reg),
        .sample_val (lane_lo)
    );

    gszr_lane u_lane_hi (
        .half       (sample_word[31:16]),
        .shift      (shift_reg),
        .sample_val (lane_hi)
    );

    assign lo_ext  = {lane_lo[gszr_pkg::SAMPLE_W-1], lane_lo};
    assign hi_ext  = {lane_hi[gszr_pkg::SAMPLE_W-1], lane_hi};
    assign start_w = gszr_pkg::VALUE_W'(gate_start);

    // ---------------- front stage ----------------
    assign fire       = s1_v_reg && (fifo_count_reg <= gszr_pkg::CNT_W'(gszr_pkg::FIFO_DEPTH - 2));
    assign item_stall = s1_v_reg && !fire;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        first_gate_next = first_gate_reg;
        gate_empty_next = gate_empty_reg;
        prev_stop_next  = prev_stop_reg;
        wpos_next       = wpos_reg;
        skip_next       = skip_reg;
        odd_next        = odd_reg;
        s1_v_next       = s1_v_reg && !fire;
        s1_next         = s1_reg;
        if (item_take)
        begin
            s1_v_next         = 1'b0;
            s1_next.v0        = lane_lo;
            s1_next.v1        = lane_hi;
            s1_next.trig_time = trigger_time;
            unique case (cmd)
                gszr_pkg::CMD_HEADER:
                begin
                    first_gate_next = 1'b0;
                    prev_stop_next  = gate_stop;
                    if (gate_stop <= gate_start)
                    begin
                        gate_empty_next = 1'b1;
                    end
                    else
                    begin
                        gate_empty_next = 1'b0;
                        wpos_next       = '0;
                        skip_next       = first_valid_half[gszr_pkg::FVH_W-1:1];
                        odd_next        = first_valid_half[0];
                        s1_v_next       = 1'b1;
                        s1_next.op      = gszr_pkg::OP_GAP;
                        s1_next.gap     = first_gate_reg
                                          ? start_w + gszr_pkg::VALUE_W'(pts_reg)
                                          : start_w - gszr_pkg::VALUE_W'(prev_stop_reg);
                    end
                end
                gszr_pkg::CMD_WORD:
                begin
                    if (!gate_empty_reg)
                    begin
                        // position saturates on very long gates
                        if (wpos_reg != '1)
                        begin
                            wpos_next = wpos_reg + gszr_pkg::WPOS_W'(1);
                        end
                        if (wpos_reg >= gszr_pkg::WPOS_W'(skip_reg))
                        begin
                            s1_v_next    = 1'b1;
                            s1_next.op   = gszr_pkg::OP_SAMPLES;
                            s1_next.e0   = !((wpos_reg == gszr_pkg::WPOS_W'(skip_reg))
                                             && odd_reg);
                            s1_next.pair = hi_ext + (s1_next.e0 ? lo_ext : '0);
                        end
                    end
                end
                gszr_pkg::CMD_END:
                begin
                    s1_v_next       = 1'b1;
                    s1_next.op      = gszr_pkg::OP_SUMMARY;
                    first_gate_next = 1'b1;
                    gate_empty_next = 1'b1;
                    prev_stop_next  = '0;
                    wpos_next       = '0;
                    skip_next       = '0;
                    odd_next        = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_gate_reg <= 1'b1;
            gate_empty_reg <= 1'b1;
            prev_stop_reg  <= '0;
            wpos_reg       <= '0;
            skip_reg       <= '0;
            odd_reg        <= 1'b0;
            s1_v_reg       <= 1'b0;
        end
        else
        begin
            first_gate_reg <= first_gate_next;
            gate_empty_reg <= gate_empty_next;
            prev_stop_reg  <= prev_stop_next;
            wpos_reg       <= wpos_next;
            skip_reg       <= skip_next;
            odd_reg        <= odd_next;
            s1_v_reg       <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    // ---------------- merge stage ----------------
    gszr_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .s1         (s1_reg),
        .scan_start (ssn_reg),
        .res0       (res0),
        .res1       (res1),
        .res_n      (merge_n)
    );

    // ---------------- result queue ----------------
    assign push_n = fire ? merge_n : 2'd0;
    assign pop    = (fifo_count_reg != '0) && !result_stall;

    assign wr_ptr_next     = wr_ptr_reg + gszr_pkg::FIFO_AW'(push_n);
    assign rd_ptr_next     = rd_ptr_reg + gszr_pkg::FIFO_AW'(pop);
    assign fifo_count_next = fifo_count_reg + gszr_pkg::CNT_W'(push_n)
                             - gszr_pkg::CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + gszr_pkg::FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_count_reg <= fifo_count_next;
        end
    end

    assign head          = fifo_mem[rd_ptr_reg];
    assign result_valid  = (fifo_count_reg != '0);
    assign kind          = head.kind;
    assign value         = head.value;
    assign scan_number   = head.scan_number;
    assign sample_count  = head.sample_count;
    assign total_count   = head.total_count;
    assign peak_value    = head.peak_value;
    assign peak_position = head.peak_position;
    assign time_out      = head.time_out;
    assign last          = head.last;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= gszr_pkg::CNT_W'(gszr_pkg::FIFO_DEPTH))
        else $error("result queue over capacity");

    a_summary_one: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_reg.op == gszr_pkg::OP_SUMMARY) |-> (merge_n == 2'd1))
        else $error("trigger summary did not give exactly one result");

    a_samples_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_reg.op == gszr_pkg::OP_SAMPLES) |=> (fifo_count_reg != '0))
        else $error("sample request left the queue empty");
`endif

endmodule

// ----- tb/tb_gated_sample_zero_run_encoder_unit.sv -----
// self-checking testbench for gated_sample_zero_run_encoder_unit
// holds its own encoder predictor and checks every result against it
// depends on gszr_pkg and the rtl of the block only
`timescale 1ns / 100ps

module tb_gated_sample_zero_run_encoder_unit;

    localparam int         QUIET_LIMIT = 4000;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]                      cmd;
        logic [31:0]                     word;
        logic [gszr_pkg::INDEX_BITS-1:0] start;
        logic [gszr_pkg::INDEX_BITS-1:0] stop;
        logic [gszr_pkg::FVH_W-1:0]      fvh;
        logic [gszr_pkg::TIME_W-1:0]     ttime;
    } request_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                              item_valid;
    logic                              item_stall;
    logic [1:0]                        cmd;
    logic [31:0]                       sample_word;
    logic [gszr_pkg::INDEX_BITS-1:0]   gate_start;
    logic [gszr_pkg::INDEX_BITS-1:0]   gate_stop;
    logic [gszr_pkg::FVH_W-1:0]        first_valid_half;
    logic [gszr_pkg::TIME_W-1:0]       trigger_time;

    logic                              result_valid;
    logic                              result_stall;
    logic [1:0]                        kind;
    logic [gszr_pkg::VALUE_W-1:0]      value;
    logic [gszr_pkg::SCAN_W-1:0]       scan_number;
    logic [gszr_pkg::NZ_W-1:0]         sample_count;
    logic [gszr_pkg::SUM_W-1:0]        total_count;
    logic [gszr_pkg::PEAK_W-1:0]       peak_value;
    logic [gszr_pkg::VALUE_W-1:0]      peak_position;
    logic [gszr_pkg::TIME_W-1:0]       time_out;
    logic                              last;

    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [3:0]                        paddr;
    logic [31:0]                       pwdata;
    logic [31:0]                       prdata;
    logic                              pready;

    // predictor copy of the registers
    logic [gszr_pkg::SSN_W-1:0]          cfg_scan_start;
    logic [gszr_pkg::PTS_W-1:0]          cfg_post_trig;
    logic signed [gszr_pkg::SHIFT_W-1:0] cfg_range;

    // predictor copy of the encoder state
    logic [31:0]                       trig_seen;
    logic [gszr_pkg::INDEX_BITS-1:0]   prev_stop;
    logic                              first_gate;
    logic                              gate_closed;
    logic                              odd_start;
    logic [gszr_pkg::WPOS_W-1:0]       word_pos;
    logic [gszr_pkg::WPOS_W-1:0]       skip_cnt;
    logic [gszr_pkg::NZ_W-1:0]         emitted_samples;
    logic [gszr_pkg::VALUE_W-1:0]      zero_total;
    logic [gszr_pkg::SUM_W-1:0]        sum_acc;
    logic [gszr_pkg::PEAK_W-1:0]       peak_acc;
    logic [gszr_pkg::VALUE_W-1:0]      peak_pos_acc;

    gszr_pkg::res_t expected_q[$];

    int send_idle_pct;
    int stall_pct;
    int items_sent;
    int results_checked;
    int mismatches;
    int quiet_cycles;

    gated_sample_zero_run_encoder_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .cmd              (cmd),
        .sample_word      (sample_word),
        .gate_start       (gate_start),
        .gate_stop        (gate_stop),
        .first_valid_half (first_valid_half),
        .trigger_time     (trigger_time),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .kind             (kind),
        .value            (value),
        .scan_number      (scan_number),
        .sample_count     (sample_count),
        .total_count      (total_count),
        .peak_value       (peak_value),
        .peak_position    (peak_position),
        .time_out         (time_out),
        .last             (last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_expected(input gszr_pkg::res_t r);
        expected_q = {expected_q, r};
    endfunction

    function automatic void clear_trigger();
        prev_stop       = '0;
        first_gate      = 1'b1;
        gate_closed     = 1'b1;
        word_pos        = '0;
        skip_cnt        = '0;
        odd_start       = 1'b0;
        emitted_samples = '0;
        zero_total      = '0;
        sum_acc         = '0;
        peak_acc        = '0;
        peak_pos_acc    = '0;
    endfunction

    function automatic void emit_sample(input logic [gszr_pkg::HALF_W-1:0] half,
                                        input logic is_last);
        logic signed [gszr_pkg::SAMPLE_W-1:0] level;
        gszr_pkg::res_t r;
        level = $signed(half) + cfg_range;
        // strictly greater keeps the first of equal peaks
        if (level > 0 && level[gszr_pkg::PEAK_W-1:0] > peak_acc)
        begin
            peak_acc     = level[gszr_pkg::PEAK_W-1:0];
            peak_pos_acc = zero_total + {2'b00, emitted_samples};
        end
        sum_acc         = sum_acc
                          + {{(gszr_pkg::SUM_W-gszr_pkg::SAMPLE_W){level[gszr_pkg::SAMPLE_W-1]}},
                             level};
        emitted_samples = emitted_samples + 1'b1;
        r       = '0;
        r.kind  = gszr_pkg::KIND_SAMPLE;
        r.value = {{(gszr_pkg::VALUE_W-gszr_pkg::SAMPLE_W){level[gszr_pkg::SAMPLE_W-1]}},
                   level};
        r.last  = is_last;
        add_expected(r);
    endfunction

    function automatic void open_gate(input request_t rq);
        logic [gszr_pkg::VALUE_W-1:0] gap;
        gszr_pkg::res_t r;
        if (first_gate)
            gap = gszr_pkg::VALUE_W'(rq.start) + gszr_pkg::VALUE_W'(cfg_post_trig);
        else
            gap = gszr_pkg::VALUE_W'(rq.start) - gszr_pkg::VALUE_W'(prev_stop);
        first_gate = 1'b0;
        prev_stop  = rq.stop;
        if (rq.stop <= rq.start)
        begin
            gate_closed = 1'b1;
            return;
        end
        gate_closed = 1'b0;
        word_pos    = '0;
        skip_cnt    = {1'b0, rq.fvh[gszr_pkg::FVH_W-1:1]};
        odd_start   = rq.fvh[0];
        zero_total  = zero_total + gap;
        if (gap != '0)
        begin
            r       = '0;
            r.kind  = gszr_pkg::KIND_RUN;
            r.value = -gap;
            r.last  = 1'b1;
            add_expected(r);
        end
    endfunction

    function automatic void take_word(input logic [31:0] w);
        logic [gszr_pkg::WPOS_W-1:0] p;
        if (gate_closed)
            return;
        p = word_pos;
        if (word_pos != '1)
            word_pos = word_pos + 1'b1;
        if (p < skip_cnt)
            return;
        if (p == skip_cnt && odd_start)
            emit_sample(w[31:16], 1'b1);
        else
        begin
            emit_sample(w[15:0], 1'b0);
            emit_sample(w[31:16], 1'b1);
        end
    endfunction

    function automatic void close_trigger(input logic [gszr_pkg::TIME_W-1:0] t);
        gszr_pkg::res_t r;
        r               = '0;
        r.kind          = gszr_pkg::KIND_SUMMARY;
        r.scan_number   = {1'b0, cfg_scan_start} + trig_seen;
        r.sample_count  = emitted_samples;
        r.total_count   = sum_acc;
        r.peak_value    = peak_acc;
        r.peak_position = peak_pos_acc;
        r.time_out      = t;
        r.last          = 1'b1;
        add_expected(r);
        trig_seen = trig_seen + 1'b1;
        clear_trigger();
    endfunction

    function automatic void predict_request(input request_t rq);
        case (rq.cmd)
            gszr_pkg::CMD_HEADER: open_gate(rq);
            gszr_pkg::CMD_WORD:   take_word(rq.word);
            gszr_pkg::CMD_END:    close_trigger(rq.ttime);
            default:              ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void note_mismatch(input string what, input logic [63:0] exp_v,
                                          input logic [63:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %0s at result %0d: expected %h, got %h",
                     what, results_checked, exp_v, act_v);
    endfunction

    function automatic void check_field(input string what, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v)
            note_mismatch(what, exp_v, act_v);
    endfunction

    always @(posedge clk)
    begin : result_check
        gszr_pkg::res_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (expected_q.size() == 0)
                note_mismatch("result with nothing expected, kind", '0, 64'(kind));
            else
            begin
                due = expected_q.pop_front();
                check_field("kind", 64'(due.kind), 64'(kind));
                check_field("value", 64'(due.value), 64'(value));
                check_field("scan_number", 64'(due.scan_number), 64'(scan_number));
                check_field("sample_count", 64'(due.sample_count), 64'(sample_count));
                check_field("total_count", 64'(due.total_count), 64'(total_count));
                check_field("peak_value", 64'(due.peak_value), 64'(peak_value));
                check_field("peak_position", 64'(due.peak_position), 64'(peak_position));
                check_field("time_out", due.time_out, time_out);
                check_field("last", 64'(due.last), 64'(last));
            end
        end
    end

    always @(posedge clk)
        result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // ends the run if the block stops moving altogether
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("gated_sample_zero_run_encoder_unit regression: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gszr_pkg::REG_SCAN_START: cfg_scan_start = data[gszr_pkg::SSN_W-1:0];
            gszr_pkg::REG_POST_TRIG:  cfg_post_trig  = data[gszr_pkg::PTS_W-1:0];
            gszr_pkg::REG_RANGE:      cfg_range      = data[gszr_pkg::SHIFT_W-1:0];
            default:                  ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [gszr_pkg::SSN_W-1:0] ssn,
                             input logic [gszr_pkg::PTS_W-1:0] pts,
                             input logic signed [gszr_pkg::SHIFT_W-1:0] rs);
        write_reg(gszr_pkg::REG_SCAN_START, {1'b0, ssn});
        write_reg(gszr_pkg::REG_POST_TRIG, {8'h00, pts});
        write_reg(gszr_pkg::REG_RANGE,
                  {{(32-gszr_pkg::SHIFT_W){rs[gszr_pkg::SHIFT_W-1]}}, rs});
    endtask

    // one request; the payload holds until it is taken
    task automatic send_request(input request_t rq);
        item_valid       <= 1'b1;
        cmd              <= rq.cmd;
        sample_word      <= rq.word;
        gate_start       <= rq.start;
        gate_stop        <= rq.stop;
        first_valid_half <= rq.fvh;
        trigger_time     <= rq.ttime;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_request(rq);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    // unused fields carry random bits so every input bit toggles
    function automatic request_t random_request(input logic [1:0] c);
        request_t rq;
        rq.cmd   = c;
        rq.word  = $urandom;
        rq.start = gszr_pkg::INDEX_BITS'($urandom);
        rq.stop  = gszr_pkg::INDEX_BITS'($urandom);
        rq.fvh   = gszr_pkg::FVH_W'($urandom);
        rq.ttime = {$urandom, $urandom};
        return rq;
    endfunction

    task automatic send_header(input logic [gszr_pkg::INDEX_BITS-1:0] start,
                               input logic [gszr_pkg::INDEX_BITS-1:0] stop,
                               input logic [gszr_pkg::FVH_W-1:0] fvh);
        request_t rq;
        rq       = random_request(gszr_pkg::CMD_HEADER);
        rq.start = start;
        rq.stop  = stop;
        rq.fvh   = fvh;
        send_request(rq);
    endtask

    task automatic send_word(input logic [31:0] w);
        request_t rq;
        rq      = random_request(gszr_pkg::CMD_WORD);
        rq.word = w;
        send_request(rq);
    endtask

    task automatic send_end(input logic [gszr_pkg::TIME_W-1:0] t);
        request_t rq;
        rq       = random_request(gszr_pkg::CMD_END);
        rq.ttime = t;
        send_request(rq);
    endtask

    // lets the block go idle before a register change
    task automatic settle();
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [gszr_pkg::HALF_W-1:0] pick_half();
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'h0001;
            default: return gszr_pkg::HALF_W'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        if ($urandom_range(99) < 60)
            return $urandom;
        return {pick_half(), pick_half()};
    endfunction

    task automatic random_traffic(input int n_requests);
        int target;
        int n_gates;
        int pick;
        logic [gszr_pkg::INDEX_BITS-1:0] cursor;
        logic [gszr_pkg::INDEX_BITS-1:0] start;
        logic [gszr_pkg::INDEX_BITS-1:0] stop;
        logic [gszr_pkg::FVH_W-1:0] fvh;
        target = items_sent + n_requests;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 8)
                send_request(random_request(2'($urandom_range(3))));
            else
            begin
                cursor  = gszr_pkg::INDEX_BITS'($urandom_range(300));
                n_gates = $urandom_range(4);
                repeat (n_gates)
                begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        start = gszr_pkg::INDEX_BITS'($urandom);
                    else if (pick < 20)
                        start = cursor - gszr_pkg::INDEX_BITS'($urandom_range(1, 50));
                    else if (pick < 35)
                        start = cursor;
                    else
                        start = cursor + gszr_pkg::INDEX_BITS'($urandom_range(1, 40));
                    pick = $urandom_range(99);
                    if (pick < 12)
                        stop = start - gszr_pkg::INDEX_BITS'($urandom_range(3));
                    else if (pick < 17)
                        stop = gszr_pkg::INDEX_BITS'($urandom);
                    else
                        stop = start + gszr_pkg::INDEX_BITS'($urandom_range(1, 60));
                    fvh = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(7));
                    send_header(start, stop, fvh);
                    repeat ($urandom_range(8))
                        send_word(random_word());
                    cursor = stop;
                end
                send_end({$urandom, $urandom});
            end
        end
        settle();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(31'd0, 24'd7, 17'sd0);
        send_word(32'h1234_5678);                 // no gate open yet
        send_header(24'd5, 24'd20, 16'd0);        // first gate adds post-trigger samples
        send_word(32'h8000_7FFF);
        send_word(32'hFFFF_0000);
        send_header(24'd30, 24'd30, 16'd0);       // empty gate
        send_word(32'h0101_0202);
        send_header(24'd10, 24'd40, 16'd3);       // overlap, one word skipped, odd start
        send_word(32'h5555_AAAA);
        send_word(32'h0003_0004);
        send_word(32'h7FFE_8001);
        send_header(24'd40, 24'd50, 16'd1);       // zero gap, odd start at once
        send_word(32'h0001_FFFF);
        send_request(random_request(CMD_UNUSED));
        send_end('1);
        send_end('0);                             // trigger with nothing in it
        send_header(24'hFFFFFF, 24'd0, 16'd0);    // empty first gate
        send_header(24'd0, 24'hFFFFFF, 16'hFFFF);
        send_word(32'hDEAD_BEEF);
        send_header(24'hFFFFFE, 24'hFFFFFF, 16'd0);
        send_word(32'h7FFF_7FFF);                 // equal peaks, first one wins
        send_end(64'h0123_4567_89AB_CDEF);
        settle();
    endtask

    // a long skip, then the odd half and a full word
    task automatic test_long_skip();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_header(24'd100, 24'd200, 16'd121);
        repeat (62)
            send_word(random_word());
        send_end({$urandom, $urandom});
        settle();
    endtask

    task automatic test_streaming_no_idle();
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(gszr_pkg::SSN_W'($urandom), gszr_pkg::PTS_W'($urandom_range(5000)),
                  gszr_pkg::SHIFT_W'($urandom));
        random_traffic(140);
    endtask

    task automatic test_sparse_requests();
        send_idle_pct = 82;
        stall_pct     = 0;
        configure(31'h7FFF_FFFF, 24'hFF_FFFF, 17'sd65535);
        random_traffic(140);
    endtask

    task automatic test_result_backpressure();
        send_idle_pct = 0;
        stall_pct     = 82;
        // most negative range shift
        configure(31'd0, 24'd0, 17'h1_0000);
        random_traffic(140);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct = 20;
        stall_pct     = 20;
        configure(gszr_pkg::SSN_W'($urandom), gszr_pkg::PTS_W'($urandom),
                  gszr_pkg::SHIFT_W'($urandom));
        random_traffic(150);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        item_valid       <= 1'b0;
        cmd              <= gszr_pkg::CMD_HEADER;
        sample_word      <= '0;
        gate_start       <= '0;
        gate_stop        <= '0;
        first_valid_half <= '0;
        trigger_time     <= '0;
        result_stall     <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        items_sent       = 0;
        results_checked  = 0;
        mismatches       = 0;
        quiet_cycles     = 0;
        cfg_scan_start   = '0;
        cfg_post_trig    = '0;
        cfg_range        = '0;
        trig_seen        = '0;
        clear_trigger();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_long_skip();
        test_streaming_no_idle();
        test_sparse_requests();
        test_result_backpressure();
        test_mixed_idling();

        item_valid <= 1'b0;
        repeat (10) @(posedge clk);
        $display("%0d requests sent over %0d triggers, %0d results checked, %0d mismatches",
                 items_sent, trig_seen, results_checked, mismatches);
        $display("covered directed corners, a long skip, five register settings"
                 , " and four idling patterns");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("gated_sample_zero_run_encoder_unit regression: pass");
        else
            $display("gated_sample_zero_run_encoder_unit regression: fail");
        $finish;
    end

endmodule
